// ===== src/ple_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg: shared constants for the positional list engine
// Command codes, status codes, cell operations and field widths.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  // command codes
  localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_AT   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READOUT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_COUNT    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // per-cycle operation broadcast along the cell chain
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_INS  = 2'd1;  // open a gap at pos, write value there
  localparam cell_op_t OP_DEL  = 2'd2;  // close the gap at pos
  localparam cell_op_t OP_ROT  = 2'd3;  // rotate entries 0..pos left by one

endpackage : ple_pkg
`default_nettype wire

// ===== src/positional_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// Insert at head or index, delete at index, read out, count.
// ----------------------------------------------------------------------------
// The list lives in a chain of DEPTH cells, one entry per cell, head in cell 0.
// Inserts, deletes and count commands act on all cells at once: each cell moves
// toward or away from its neighbor in the same clock, so a command is
// accepted every cycle while the result register drains. A readout emits one
// transfer per entry, one per cycle while the result register drains, by
// rotating the occupied cells past the head; it holds off new commands until
// its final transfer is loaded, after which the list is back in its original
// order. Every command returns at least one result transfer, the final one
// with tlast set. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // action[2:0], position[7:3], item_value[39:8]
  input  wire [ple_pkg::S_TDATA_W-1:0]     s_tdata,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // out_value[31:0], list_count[36:32], status[38:37], zero[39]
  output logic [ple_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                             m_tlast,
  output logic                             m_tvalid,
  input  wire                              m_tready
);
  import ple_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                state;
  logic                state_next;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_next;
  logic [CW-1:0]       rem;
  logic [CW-1:0]       rem_next;

  logic [ACTION_W-1:0] action;
  logic [POS_W-1:0]    position;
  logic [VALUE_W-1:0]  item_value;
  logic [XW-1:0]       pos_x;
  logic [XW-1:0]       cnt_x;

  logic                accept;
  logic                slot_free;
  logic                load_out;
  logic                last_out;
  logic [VALUE_W-1:0]  value_out;
  logic [STATUS_W-1:0] status_out;

  cell_op_t            cell_op;
  logic [CW-1:0]       cell_pos;
  logic [VALUE_W-1:0]  cell_data [DEPTH];

  assign action     = s_tdata[ACTION_W-1:0];
  assign position   = s_tdata[ACTION_W +: POS_W];
  assign item_value = s_tdata[ACTION_W+POS_W +: VALUE_W];
  assign pos_x      = XW'(position);
  assign cnt_x      = XW'(cnt);

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    rem_next   = rem;
    cell_op    = OP_HOLD;
    cell_pos   = '0;
    load_out   = 1'b0;
    last_out   = 1'b1;
    value_out  = '0;
    status_out = ST_OK;

    if (state == S_IDLE) begin
      if (accept) begin
        load_out = 1'b1;
        case (action)
          ACT_INS_HEAD: begin
            if (cnt == FULL_CNT) begin
              status_out = ST_FULL;
            end else begin
              cell_op  = OP_INS;
              cnt_next = cnt + ONE_CNT;
            end
          end
          ACT_INS_AT: begin
            if (cnt == FULL_CNT) begin
              status_out = ST_FULL;
            end else if (cnt == '0) begin
              cell_op  = OP_INS;
              cnt_next = ONE_CNT;
            end else if (pos_x > cnt_x) begin
              status_out = ST_RANGE;
            end else begin
              cell_op  = OP_INS;
              cell_pos = pos_x[CW-1:0];
              cnt_next = cnt + ONE_CNT;
            end
          end
          ACT_DELETE: begin
            if (cnt == '0) begin
              status_out = ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
              status_out = ST_RANGE;
            end else begin
              cell_op  = OP_DEL;
              cell_pos = pos_x[CW-1:0];
              cnt_next = cnt - ONE_CNT;
            end
          end
          ACT_READOUT: begin
            if (cnt == '0) begin
              status_out = ST_EMPTY;
            end else begin
              value_out = cell_data[0];
              cell_op   = OP_ROT;
              cell_pos  = cnt - ONE_CNT;
              last_out  = (cnt == ONE_CNT);
              if (cnt != ONE_CNT) begin
                rem_next   = cnt - ONE_CNT;
                state_next = S_READ;
              end
            end
          end
          default: begin
            // count, and unused codes answer the same way
            status_out = ST_OK;
          end
        endcase
      end
    end else begin
      if (slot_free) begin
        load_out  = 1'b1;
        value_out = cell_data[0];
        cell_op   = OP_ROT;
        cell_pos  = cnt - ONE_CNT;
        last_out  = (rem == ONE_CNT);
        rem_next  = rem - ONE_CNT;
        if (rem == ONE_CNT) begin
          state_next = S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      rem      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rem   <= rem_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, status_out, COUNT_W'(cnt_next), value_out};
      m_tlast <= last_out;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] left_d;
    logic [VALUE_W-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_d = item_value;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_body
      assign right_d = cell_data[i+1];
    end

    ple_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .pos        (cell_pos),
      .ins_value  (item_value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

`ifndef ASSERT_OFF
  a_read_holds_output : assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> m_tvalid)
    else $error("readout in progress without a pending result");

  a_no_accept_when_stalled : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("command taken while result register is stalled");

  a_count_bounded : assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_CNT)
    else $error("entry count exceeds depth");

  a_single_result : assert property (@(posedge clk) disable iff (rst)
    (accept && action != ACT_READOUT) |=> (m_tvalid && m_tlast))
    else $error("non-readout command did not give a final result");
`endif

endmodule : positional_list_engine
`default_nettype wire

// ===== src/ple_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list chain
// Holds one entry and picks its next value from itself, its neighbors, the
// list head or the inserted value, based on the broadcast operation.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF,
  parameter int INDEX = 0
) (
  input  wire                              clk,
  input  wire ple_pkg::cell_op_t           op,
  input  wire [$clog2(DEPTH+1)-1:0]        pos,
  input  wire [ple_pkg::VALUE_W-1:0]       ins_value,
  input  wire [ple_pkg::VALUE_W-1:0]       left_data,
  input  wire [ple_pkg::VALUE_W-1:0]       right_data,
  input  wire [ple_pkg::VALUE_W-1:0]       head_data,
  output logic [ple_pkg::VALUE_W-1:0]      data
);
  import ple_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic [VALUE_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (op)
      OP_INS: begin
        if (IDX == pos) begin
          data_next = ins_value;
        end else if (IDX > pos) begin
          data_next = left_data;
        end
      end
      OP_DEL: begin
        if (IDX >= pos) begin
          data_next = right_data;
        end
      end
      OP_ROT: begin
        // pos carries the tail index; the head wraps around to it
        if (IDX == pos) begin
          data_next = head_data;
        end else if (IDX < pos) begin
          data_next = right_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule : ple_cell
`default_nettype wire
